/* hw/rtl/slpi_pkg.sv */
// ----------------------------------------------------------------------------
// slpi_pkg: shared types and constants for the slew-limited PI position loop
// Field widths, register indexes, fixed loop constants and the beat,
// config and step-result structures.
// ----------------------------------------------------------------------------
package slpi_pkg;

    localparam int POS_W      = 24;   // Q16.8 position
    localparam int ERR_W      = 25;   // position difference
    localparam int SPEED_W    = 16;   // Q2.14 speed
    localparam int INTEG_W    = 48;   // error integral
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int TIME_W     = 16;   // Q0.16 seconds
    localparam int TOL_W      = 16;
    localparam int ISAT_W     = 27;   // pre-saturated integral for the I product
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FF     = 3'd6;

    // Speed floors (-0.8 and -0.3 in Q2.14) and the low zone edge (8 rotations)
    localparam logic signed [SPEED_W-1:0] NEG_FLOOR_ALL  = -16'sd13107;
    localparam logic signed [SPEED_W-1:0] NEG_FLOOR_LOW  = -16'sd4915;
    localparam logic signed [POS_W-1:0]   LOW_ZONE_LIMIT = 24'sd2048;

    // Integral magnitude beyond which any nonzero I gain saturates the I term
    localparam logic signed [INTEG_W-1:0] ISAT_HI = 48'sd33554432;
    localparam logic signed [INTEG_W-1:0] ISAT_LO = -48'sd33554432;

    // Saturation bounds of the 48-bit integral, in the 49-bit sum width
    localparam logic signed [INTEG_W:0] INTEG_MAX = 49'sd140737488355327;
    localparam logic signed [INTEG_W:0] INTEG_MIN = -49'sd140737488355328;

    typedef struct packed {
        logic        [GAIN_W-1:0]  prop_gain;
        logic        [GAIN_W-1:0]  integ_gain;
        logic        [LIM_W-1:0]   integ_limit;
        logic        [LIM_W-1:0]   speed_limit;
        logic        [GAIN_W-1:0]  accel_limit;
        logic        [TOL_W-1:0]   tolerance;
        logic signed [SPEED_W-1:0] hold_ff;
    } cfg_t;

    typedef struct packed {
        logic                    op;
        logic signed [POS_W-1:0] target_position;
        logic signed [POS_W-1:0] measured_position;
        logic        [TIME_W-1:0] elapsed_time;
    } item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] drive;
        logic                      at_target;
        logic                      restart;
        logic                      settled;
        logic signed [SPEED_W-1:0] last_speed_next;
        logic signed [INTEG_W-1:0] integral_next;
    } step_t;

endpackage

/* hw/rtl/slpi_step.sv */
// ----------------------------------------------------------------------------
// slpi_step: one control step of the position loop
// Combinational: error, clamped P and I terms, slew limit, speed floors,
// integral update and saturated drive, from one beat and the loop state.
// ----------------------------------------------------------------------------
module slpi_step
    import slpi_pkg::*;
(
    input  cfg_t                      cfg,
    input  item_t                     item,
    input  logic signed [SPEED_W-1:0] last_speed,
    input  logic signed [INTEG_W-1:0] integral,
    output step_t                     res
);

    logic signed [ERR_W-1:0]     err;
    logic        [ERR_W-1:0]     mag;
    logic                        settled;
    logic signed [ISAT_W-1:0]    isat;
    logic signed [43:0]          iprod;
    logic signed [33:0]          ishift;
    logic signed [33:0]          ilim;
    logic signed [SPEED_W-1:0]   iterm;
    logic signed [41:0]          pprod;
    logic signed [39:0]          pterm;
    logic signed [40:0]          vel_raw;
    logic signed [40:0]          slim;
    logic signed [SPEED_W-1:0]   vel;
    logic        [31:0]          sprod;
    logic signed [17:0]          stp;
    logic signed [17:0]          diff;
    logic signed [17:0]          slew;
    logic signed [SPEED_W-1:0]   spd;
    logic signed [INTEG_W:0]     isum;
    logic signed [INTEG_W-1:0]   integ_upd;
    logic signed [SPEED_W:0]     drv_raw;
    logic signed [SPEED_W-1:0]   drv;

    always_comb begin
        // Position error and settle test
        err     = ERR_W'(item.target_position) - ERR_W'(item.measured_position);
        mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        settled = mag < {{(ERR_W-TOL_W){1'b0}}, cfg.tolerance};

        // I term: a large integral saturates the term anyway, so narrow it first
        if (integral > ISAT_HI) begin
            isat = ISAT_W'(ISAT_HI);
        end else if (integral < ISAT_LO) begin
            isat = ISAT_W'(ISAT_LO);
        end else begin
            isat = ISAT_W'(integral);
        end
        iprod  = $signed({1'b0, cfg.integ_gain}) * isat;
        ishift = iprod[43:10];
        ilim   = $signed({19'b0, cfg.integ_limit});
        if (ishift > ilim) begin
            iterm = SPEED_W'(ilim);
        end else if (ishift < -ilim) begin
            iterm = SPEED_W'(-ilim);
        end else begin
            iterm = SPEED_W'(ishift);
        end

        // P term plus I term, clamped to the speed limit
        pprod   = $signed({1'b0, cfg.prop_gain}) * err;
        pterm   = pprod[41:2];
        vel_raw = 41'(pterm) + 41'(iterm);
        slim    = $signed({26'b0, cfg.speed_limit});
        if (vel_raw > slim) begin
            vel = SPEED_W'(slim);
        end else if (vel_raw < -slim) begin
            vel = SPEED_W'(-slim);
        end else begin
            vel = SPEED_W'(vel_raw);
        end

        // Slew limit: move at most accel_limit * elapsed_time
        sprod = cfg.accel_limit * item.elapsed_time;
        stp   = $signed({2'b0, sprod[31:16]});
        diff  = 18'(vel) - 18'(last_speed);
        if (diff > stp) begin
            slew = 18'(last_speed) + stp;
        end else if (diff < -stp) begin
            slew = 18'(last_speed) - stp;
        end else begin
            slew = 18'(vel);
        end
        spd = SPEED_W'(slew);

        // Downward speed floors
        if (spd < NEG_FLOOR_ALL) begin
            spd = NEG_FLOOR_ALL;
        end
        if (spd < NEG_FLOOR_LOW && item.measured_position < LOW_ZONE_LIMIT) begin
            spd = NEG_FLOOR_LOW;
        end

        // Saturating integral update
        isum = 49'(integral) + 49'(err);
        if (isum > INTEG_MAX) begin
            integ_upd = INTEG_W'(INTEG_MAX);
        end else if (isum < INTEG_MIN) begin
            integ_upd = INTEG_W'(INTEG_MIN);
        end else begin
            integ_upd = INTEG_W'(isum);
        end

        // Drive with hold feed-forward, saturated
        drv_raw = 17'(spd) + 17'(cfg.hold_ff);
        if (drv_raw > 17'sd32767) begin
            drv = 16'sh7fff;
        end else if (drv_raw < -17'sd32768) begin
            drv = -16'sh8000;
        end else begin
            drv = SPEED_W'(drv_raw);
        end

        // Select by operation and settle state
        res.restart = item.op;
        res.settled = !item.op && settled;
        priority if (item.op) begin
            res.drive           = '0;
            res.at_target       = 1'b0;
            res.last_speed_next = '0;
            res.integral_next   = '0;
        end else if (settled) begin
            res.drive           = '0;
            res.at_target       = 1'b1;
            res.last_speed_next = last_speed;
            res.integral_next   = '0;
        end else begin
            res.drive           = drv;
            res.at_target       = 1'b0;
            res.last_speed_next = spd;
            res.integral_next   = integ_upd;
        end
    end

endmodule

/* hw/rtl/slew_limited_pi_position_loop_top.sv */
// ----------------------------------------------------------------------------
// slew_limited_pi_position_loop_top: PI position loop with slew limit
// Throughput: one beat per cycle while the sink keeps m_tready high; the loop
// state (integral, last speed) is updated in the single step stage between
// the input and output registers.
// Reset (aresetn low, synchronous): registers return to defaults, integral
// and last speed clear, both channels empty.
// ----------------------------------------------------------------------------
module slew_limited_pi_position_loop_top
    import slpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // target_position[23:0], measured_position[47:24],
                                             // elapsed_time[63:48]
    input  logic                  s_tuser,   // op[0]
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // drive[15:0]
    output logic                  m_tuser    // at_target[0]
);

    cfg_t                      cfg_reg;
    cfg_t                      cfg_next;
    item_t                     in_reg;
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [SPEED_W-1:0] drive_reg;
    logic                      at_target_reg;
    logic signed [SPEED_W-1:0] last_speed_reg;
    logic signed [SPEED_W-1:0] last_speed_next;
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [INTEG_W-1:0] integral_next;
    logic                      advance;
    logic                      proc;
    logic                      s_accept;
    step_t                     res;

    // Handshake: the output register parts the two sides
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = at_target_reg;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PROP_GAIN:   cfg_next.prop_gain   = cfg_data;
                REG_INTEG_GAIN:  cfg_next.integ_gain  = cfg_data;
                REG_INTEG_LIMIT: cfg_next.integ_limit = cfg_data[LIM_W-1:0];
                REG_SPEED_LIMIT: cfg_next.speed_limit = cfg_data[LIM_W-1:0];
                REG_ACCEL_LIMIT: cfg_next.accel_limit = cfg_data;
                REG_TOLERANCE:   cfg_next.tolerance   = cfg_data;
                REG_HOLD_FF:     cfg_next.hold_ff     = $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain   <= 16'd256;
            cfg_reg.integ_gain  <= 16'd0;
            cfg_reg.integ_limit <= 15'd4096;
            cfg_reg.speed_limit <= 15'd16384;
            cfg_reg.accel_limit <= 16'd16384;
            cfg_reg.tolerance   <= 16'd128;
            cfg_reg.hold_ff     <= 16'sd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Control step
    slpi_step u_step (
        .cfg        (cfg_reg),
        .item       (in_reg),
        .last_speed (last_speed_reg),
        .integral   (integral_reg),
        .res        (res)
    );

    // Stage valids and loop state
    always_comb begin
        in_valid_next   = in_valid_reg;
        out_valid_next  = out_valid_reg;
        last_speed_next = last_speed_reg;
        integral_next   = integral_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (proc) begin
            in_valid_next   = 1'b0;
            out_valid_next  = 1'b1;
            last_speed_next = res.last_speed_next;
            integral_next   = res.integral_next;
        end
        if (s_accept) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_speed_reg <= '0;
            integral_reg   <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            last_speed_reg <= last_speed_next;
            integral_reg   <= integral_next;
        end
    end

    // Payload: capture the input beat, load the result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg.op                <= s_tuser;
            in_reg.target_position   <= $signed(s_tdata[23:0]);
            in_reg.measured_position <= $signed(s_tdata[47:24]);
            in_reg.elapsed_time      <= s_tdata[63:48];
        end
        if (proc) begin
            drive_reg     <= res.drive;
            at_target_reg <= res.at_target;
        end
    end

    // A settled result always carries zero drive
    a_settled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && at_target_reg) |-> (drive_reg == '0))
        else $error("settled result with nonzero drive");

    // Restart clears the loop state
    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_reg.op) |=> (last_speed_reg == '0 && integral_reg == '0))
        else $error("restart did not clear loop state");

    // A settled step keeps the speed and clears the integral
    a_settled_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && res.settled) |=> ($stable(last_speed_reg) && integral_reg == '0))
        else $error("settled step changed speed or kept integral");

    // Stored speed never drops below the global floor
    a_speed_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        last_speed_reg >= NEG_FLOOR_ALL)
        else $error("stored speed below floor");

    // A result waiting on a stalled sink is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !proc)
        else $error("result overwritten while stalled");

endmodule
